[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define MTEP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mtep_pkg.sv]
// Shared types and constants of the MIDI track event parser.
// No dependencies; imported by every module of the block.
package mtep_pkg;

	localparam int DELTA_BYTES_DEF = 4;
	localparam int TICK_BITS_DEF   = 32;
	localparam int NUM_CHAN        = 16;
	localparam int TDATA_W         = 160;

	typedef enum logic [3:0] {
		EK_NOTEOFF   = 4'd0,
		EK_NOTEON    = 4'd1,
		EK_POLYPRESS = 4'd2,
		EK_CONTROL   = 4'd3,
		EK_PROGRAM   = 4'd4,
		EK_CHANPRESS = 4'd5,
		EK_PITCH     = 4'd6,
		EK_TEMPO     = 4'd7,
		EK_ENDTRACK  = 4'd8,
		EK_OTHERMETA = 4'd9,
		EK_SYSEX     = 4'd10,
		EK_SYSCOMMON = 4'd11,
		EK_BADHEADER = 4'd12,
		EK_UNKNOWN   = 4'd13
	} event_kind_t;

	typedef enum logic [11:0] {
		PH_TAG    = 12'b0000_0000_0001,
		PH_LEN    = 12'b0000_0000_0010,
		PH_DELTA  = 12'b0000_0000_0100,
		PH_STATUS = 12'b0000_0000_1000,
		PH_CD1    = 12'b0000_0001_0000,
		PH_CD2    = 12'b0000_0010_0000,
		PH_MTYPE  = 12'b0000_0100_0000,
		PH_MLEN   = 12'b0000_1000_0000,
		PH_MDATA  = 12'b0001_0000_0000,
		PH_SYSEX  = 12'b0010_0000_0000,
		PH_SD1    = 12'b0100_0000_0000,
		PH_SD2    = 12'b1000_0000_0000
	} phase_t;

	// "MTrk"
	localparam logic [7:0] TAG_M = 8'd77;
	localparam logic [7:0] TAG_T = 8'd84;
	localparam logic [7:0] TAG_R = 8'd114;
	localparam logic [7:0] TAG_K = 8'd107;

	localparam logic [7:0] NOTE_NONE  = 8'd255;
	localparam logic [7:0] META_TEMPO = 8'd81;
	localparam logic [7:0] META_END   = 8'd47;
	localparam logic [7:0] ST_META    = 8'hFF;
	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] ST_MTC     = 8'hF1;
	localparam logic [7:0] ST_SONGPOS = 8'hF2;
	localparam logic [7:0] ST_SONGSEL = 8'hF3;
	localparam logic [7:0] ST_TUNE    = 8'hF6;
	localparam logic [7:0] ST_EOX     = 8'hF7;

	typedef struct packed {
		event_kind_t  kind;
		logic [3:0]   channel;
		logic [7:0]   data_first;
		logic [7:0]   data_second;
		logic [27:0]  delta_ticks;
		logic [23:0]  tempo_value;
		logic [7:0]   meta_code;
		logic [7:0]   ended_note;
		logic [6:0]   ended_velocity;
		logic [31:0]  ended_ticks;
		logic [31:0]  chunk_length;
	} result_t;

	// parser -> channel table
	typedef struct packed {
		logic         add_en;   // delta done: add to sounding channels
		logic [27:0]  delta;
		logic         wr_en;    // note-on/off: load note and velocity
		logic         clr_ticks;
		logic [3:0]   ch;
		logic [7:0]   note;
		logic [6:0]   vel;
	} chan_cmd_t;

	// channel table -> parser, entry selected by chan_cmd_t.ch
	typedef struct packed {
		logic [7:0]   note;
		logic [6:0]   vel;
		logic [31:0]  ticks;
	} chan_rd_t;

endpackage

[sv/mtep_chan_table.sv]
// Per-channel note, velocity and sounding-tick registers.
// Depends on mtep_pkg; driven by mtep_parser commands.
module mtep_chan_table import mtep_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  chan_cmd_t cmd,
	output chan_rd_t  rd
);

	localparam logic [32:0] TICK_MAX = (33'd1 << TICK_BITS) - 33'd1;

	logic [7:0]           note_q  [NUM_CHAN];
	logic [6:0]           vel_q   [NUM_CHAN];
	logic [TICK_BITS-1:0] ticks_q [NUM_CHAN];

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
		logic [32:0] sum;
		logic        sel;

		assign sum = 33'(ticks_q[c]) + 33'(cmd.delta);
		assign sel = (cmd.ch == 4'(c));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				note_q[c]  <= NOTE_NONE;
				vel_q[c]   <= '0;
				ticks_q[c] <= '0;
			end else begin
				if (cmd.add_en && vel_q[c] != '0) begin
					ticks_q[c] <= (sum > TICK_MAX) ? TICK_MAX[TICK_BITS-1:0]
						: sum[TICK_BITS-1:0];
				end else if (cmd.clr_ticks && sel) begin
					ticks_q[c] <= '0;
				end
				if (cmd.wr_en && sel) begin
					note_q[c] <= cmd.note;
					vel_q[c]  <= cmd.vel;
				end
			end
		end
	end

	assign rd.note  = note_q[cmd.ch];
	assign rd.vel   = vel_q[cmd.ch];
	assign rd.ticks = 32'(ticks_q[cmd.ch]);

endmodule

[sv/mtep_parser.sv]
// Byte-level track parser: phase machine, header/delta/meta accumulators.
// Depends on mtep_pkg; reads and updates mtep_chan_table through structs.
module mtep_parser import mtep_pkg::*; #(
	parameter int DELTA_BYTES = DELTA_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic [7:0] in_byte,
	input  chan_rd_t  rd,
	output logic      res_valid,
	output result_t   res,
	output chan_cmd_t cmd
);

	localparam logic [2:0] DELTA_LAST = 3'(DELTA_BYTES);

	phase_t      phase_q, phase_n;
	logic [2:0]  hdr_cnt_q, hdr_cnt_n;
	logic [31:0] len_q, len_n;
	logic [27:0] delta_q, delta_n;
	logic [2:0]  dcnt_q, dcnt_n;
	logic [7:0]  status_q, status_n;
	logic [7:0]  first_q, first_n;
	logic [7:0]  mtype_q, mtype_n;
	logic [7:0]  mleft_q, mleft_n;
	logic [23:0] tempo_q, tempo_n;

	logic        emit, do_chan, do_sysc, do_meta, do_start;
	logic [7:0]  ev_first, ev_second;
	logic [7:0]  tag_exp;
	event_kind_t chan_kind;

	always_comb begin
		unique case (hdr_cnt_q[1:0])
			2'd0: tag_exp = TAG_M;
			2'd1: tag_exp = TAG_T;
			2'd2: tag_exp = TAG_R;
			default: tag_exp = TAG_K;
		endcase
	end

	assign chan_kind = event_kind_t'({1'b0, status_q[6:4]});

	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		len_n     = len_q;
		delta_n   = delta_q;
		dcnt_n    = dcnt_q;
		status_n  = status_q;
		first_n   = first_q;
		mtype_n   = mtype_q;
		mleft_n   = mleft_q;
		tempo_n   = tempo_q;
		emit      = 1'b0;
		do_chan   = 1'b0;
		do_sysc   = 1'b0;
		do_meta   = 1'b0;
		do_start  = 1'b0;
		ev_first  = first_q;
		ev_second = in_byte;

		res                = '0;
		res.kind           = EK_UNKNOWN;
		res.delta_ticks    = delta_q;
		res.ended_note     = NOTE_NONE;
		res.chunk_length   = len_q;

		cmd           = '0;
		cmd.ch        = status_q[3:0];
		cmd.delta     = delta_n;

		unique case (phase_q)
			PH_TAG: begin
				if (in_byte == tag_exp) begin
					if (hdr_cnt_q == 3'd3) begin
						phase_n   = PH_LEN;
						hdr_cnt_n = '0;
						len_n     = '0;
					end else begin
						hdr_cnt_n = hdr_cnt_q + 3'd1;
					end
				end else begin
					emit            = 1'b1;
					delta_n         = '0;
					res.kind        = EK_BADHEADER;
					res.delta_ticks = '0;
					res.meta_code   = in_byte;
					hdr_cnt_n       = (in_byte == TAG_M) ? 3'd1 : 3'd0;
				end
			end
			PH_LEN: begin
				len_n = {len_q[23:0], in_byte};
				if (hdr_cnt_q == 3'd3) begin
					hdr_cnt_n = '0;
					do_start  = 1'b1;
				end else begin
					hdr_cnt_n = hdr_cnt_q + 3'd1;
				end
			end
			PH_DELTA: begin
				delta_n = {delta_q[20:0], in_byte[6:0]};
				dcnt_n  = dcnt_q + 3'd1;
				if (!in_byte[7] || dcnt_n >= DELTA_LAST) begin
					// channels add the completed delta, this byte included
					cmd.delta  = delta_n;
					cmd.add_en = step;
					phase_n    = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (!in_byte[7]) begin
					// running status is not supported
					emit           = 1'b1;
					res.data_first = in_byte;
					do_start       = 1'b1;
				end else begin
					status_n = in_byte;
					first_n  = '0;
					if (in_byte < ST_SYSEX) begin
						phase_n = PH_CD1;
					end else begin
						unique case (in_byte)
							ST_META: phase_n = PH_MTYPE;
							ST_SYSEX: phase_n = PH_SYSEX;
							ST_MTC, ST_SONGPOS, ST_SONGSEL: phase_n = PH_SD1;
							ST_TUNE, ST_EOX: begin
								do_sysc   = 1'b1;
								ev_first  = '0;
								ev_second = '0;
							end
							default: begin
								emit          = 1'b1;
								res.meta_code = in_byte;
								do_start      = 1'b1;
							end
						endcase
					end
				end
			end
			PH_CD1: begin
				first_n = in_byte;
				if (status_q[7:5] == 3'b110) begin
					// program and channel pressure carry one byte
					do_chan   = 1'b1;
					ev_first  = in_byte;
					ev_second = '0;
				end else begin
					phase_n = PH_CD2;
				end
			end
			PH_CD2: begin
				do_chan = 1'b1;
			end
			PH_MTYPE: begin
				mtype_n = in_byte;
				phase_n = PH_MLEN;
			end
			PH_MLEN: begin
				mleft_n = in_byte;
				tempo_n = '0;
				if (in_byte == '0) do_meta = 1'b1;
				else phase_n = PH_MDATA;
			end
			PH_MDATA: begin
				tempo_n = {tempo_q[15:0], in_byte};
				mleft_n = mleft_q - 8'd1;
				if (mleft_n == '0) do_meta = 1'b1;
			end
			PH_SYSEX: begin
				if (in_byte == ST_EOX) begin
					emit          = 1'b1;
					res.kind      = EK_SYSEX;
					res.meta_code = status_q;
					do_start      = 1'b1;
				end
			end
			PH_SD1: begin
				first_n = in_byte;
				if (status_q == ST_SONGPOS) begin
					phase_n = PH_SD2;
				end else begin
					do_sysc   = 1'b1;
					ev_first  = in_byte;
					ev_second = '0;
				end
			end
			PH_SD2: begin
				do_sysc = 1'b1;
			end
			default: begin
				phase_n   = PH_TAG;
				hdr_cnt_n = '0;
			end
		endcase

		if (do_chan) begin
			emit            = 1'b1;
			do_start        = 1'b1;
			res.kind        = chan_kind;
			res.channel     = status_q[3:0];
			res.data_first  = ev_first;
			res.data_second = ev_second;
			if (chan_kind == EK_NOTEOFF) begin
				res.ended_note     = rd.note;
				res.ended_velocity = rd.vel;
				res.ended_ticks    = rd.ticks;
				cmd.clr_ticks      = step;
			end
			cmd.wr_en = step && (chan_kind == EK_NOTEOFF || chan_kind == EK_NOTEON);
			cmd.note  = ev_first;
			cmd.vel   = ev_second[6:0];
		end

		if (do_sysc) begin
			emit            = 1'b1;
			do_start        = 1'b1;
			res.kind        = EK_SYSCOMMON;
			res.data_first  = ev_first;
			res.data_second = ev_second;
			// a status taken in this very request is not in status_q yet
			res.meta_code   = (phase_q == PH_STATUS) ? in_byte : status_q;
		end

		if (do_meta) begin
			emit          = 1'b1;
			res.meta_code = mtype_q;
			if (mtype_q == META_TEMPO) begin
				res.kind        = EK_TEMPO;
				res.tempo_value = tempo_n;
				do_start        = 1'b1;
			end else if (mtype_q == META_END) begin
				res.kind  = EK_ENDTRACK;
				phase_n   = PH_TAG;
				hdr_cnt_n = '0;
			end else begin
				res.kind = EK_OTHERMETA;
				do_start = 1'b1;
			end
		end

		if (do_start) begin
			phase_n = PH_DELTA;
			delta_n = '0;
			dcnt_n  = '0;
		end
	end

	assign res_valid = step && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			delta_q   <= '0;
			dcnt_q    <= '0;
			status_q  <= '0;
			first_q   <= '0;
			mtype_q   <= '0;
			mleft_q   <= '0;
			tempo_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			hdr_cnt_q <= hdr_cnt_n;
			len_q     <= len_n;
			delta_q   <= delta_n;
			dcnt_q    <= dcnt_n;
			status_q  <= status_n;
			first_q   <= first_n;
			mtype_q   <= mtype_n;
			mleft_q   <= mleft_n;
			tempo_q   <= tempo_n;
		end
	end

endmodule

[sv/midi_track_event_parser_unit.sv]
// MIDI track chunk parser, one byte per request.
// Input: s_axis carries raw track bytes ("MTrk", 32-bit length, events).
// Output: m_axis carries at most one decoded event per input byte; bytes
// inside an event (delta, data, meta payload) produce nothing.
// Pipeline: input register -> single-pass decode -> result register.
// A byte accepted on s_axis is held in the input register and its event
// is registered in the result register. Throughput: one byte per cycle
// unless m_axis stalls; decode and 16-channel tick update share the cycle.
// A bad tag byte gives a badheader event; endtrack rearms the tag search.
// Reset: clears the parser to tag search, channel notes to none (255),
// velocities and tick counts to zero; all 16 channels are empty.
// Stall: while a result waits on m_axis, a byte in the input register
// is held, with s_axis_tready low, until the result is taken.
// Depends on mtep_pkg, mtep_parser and mtep_chan_table.
module midi_track_event_parser_unit import mtep_pkg::*; #(
	parameter int DELTA_BYTES = DELTA_BYTES_DEF,
	parameter int TICK_BITS   = TICK_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // byte_in
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// channel, data_first, data_second, delta_ticks, tempo_value, meta_code,
	// ended_note, ended_velocity, ended_ticks, chunk_length, zero pad
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [3:0]         m_axis_tuser    // event_kind
);

	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	chan_cmd_t  cmd;
	chan_rd_t   rd;
	logic       out_valid_q;
	result_t    out_q;

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) byte_s1 <= s_axis_tdata;
	end

	mtep_parser #(
		.DELTA_BYTES(DELTA_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.in_byte  (byte_s1),
		.rd       (rd),
		.res_valid(res_valid),
		.res      (res),
		.cmd      (cmd)
	);

	mtep_chan_table #(
		.TICK_BITS(TICK_BITS)
	) u_chan (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rd    (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {1'b0, out_q.chunk_length, out_q.ended_ticks,
		out_q.ended_velocity, out_q.ended_note, out_q.meta_code,
		out_q.tempo_value, out_q.delta_ticks, out_q.data_second,
		out_q.data_first, out_q.channel};

endmodule

[sv/mtep_checker.sv]
// Port-level checks on the MIDI track parser, bound to the top level.
// Depends on mtep_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtep_checker import mtep_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic [3:0]         m_axis_tuser
);

	// a stalled result holds
	`MTEP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// input only backs up behind a stalled output
	`MTEP_ASSERT_IMPLY(a_in_stall, s_axis_tvalid && !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with output free")

	// ended-note fields only on note-off
	`MTEP_ASSERT_IMPLY(a_ended_none, m_axis_tvalid && m_axis_tuser != EK_NOTEOFF, m_axis_tdata[87:80] == NOTE_NONE && m_axis_tdata[126:88] == '0, "ended note fields set outside note-off")

	// tempo field only on tempo events
	`MTEP_ASSERT_IMPLY(a_tempo_only, m_axis_tvalid && m_axis_tuser != EK_TEMPO, m_axis_tdata[71:48] == '0, "tempo set outside tempo event")

endmodule

bind midi_track_event_parser_unit mtep_checker u_checker (.*);
